// ===== rtl/cpd_pkg.sv =====
// shared types and constants for the closest pair distance block
// no dependencies
package cpd_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_W = 31;
    localparam int DIST_W = 63;
    localparam int SQ_W = 62;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ_I,
        ST_READ_J,
        ST_WAIT,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clr_count;
        logic wr_point;
        logic ld_i;
        logic ld_j;
        logic mul;
        logic acc;
        logic clr_best;
    } cmd_t;

endpackage

// ===== rtl/cpd_ram.sv =====
// generic single write, single read ram with registered read
// no dependencies
module cpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/cpd_datapath.sv =====
// point store, pair distance unit and running minimum
// depends on cpd_pkg and cpd_ram
module cpd_datapath #(
    parameter int MAX_POINTS = cpd_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cpd_pkg::cmd_t                       cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]       raddr,
    input  logic signed [cpd_pkg::COORD_W-1:0]  x_in,
    input  logic signed [cpd_pkg::COORD_W-1:0]  y_in,
    output logic [$clog2(MAX_POINTS+1)-1:0]     count,
    output logic [cpd_pkg::DIST_W-1:0]          best,
    output logic                                found
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int CW_ = cpd_pkg::COORD_W;

    logic [CW-1:0] count_reg;
    logic [CW_-1:0] xr, yr;
    logic signed [CW_-1:0] xi_reg, yi_reg;
    logic [CW_-1:0] dx_reg, dy_reg;
    logic [cpd_pkg::SQ_W-1:0] sx_reg, sy_reg;
    logic [cpd_pkg::DIST_W-1:0] best_reg;
    logic found_reg;
    logic signed [CW_:0] dx, dy;
    logic [cpd_pkg::DIST_W-1:0] d;
    logic we;

    assign we = cmd.wr_point && (count_reg < CW'(MAX_POINTS));

    cpd_ram #(.WIDTH(CW_), .DEPTH(MAX_POINTS)) u_xmem (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(x_in),
        .raddr(raddr), .rdata(xr)
    );
    cpd_ram #(.WIDTH(CW_), .DEPTH(MAX_POINTS)) u_ymem (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(y_in),
        .raddr(raddr), .rdata(yr)
    );

    // signed differences and sum of squares
    always_comb
    begin
        dx = {xi_reg[CW_-1], xi_reg} - {xr[CW_-1], xr};
        dy = {yi_reg[CW_-1], yi_reg} - {yr[CW_-1], yr};
        d = {1'b0, sx_reg} + {1'b0, sy_reg};
    end

    // point count and pair found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.clr_best)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.acc)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // pair pipeline: anchor, difference, square, minimum
    always_ff @(posedge clk)
    begin
        if (cmd.ld_i)
        begin
            xi_reg <= xr;
            yi_reg <= yr;
        end
        if (cmd.ld_j)
        begin
            dx_reg <= dx[CW_] ? CW_'(-dx) : dx[CW_-1:0];
            dy_reg <= dy[CW_] ? CW_'(-dy) : dy[CW_-1:0];
        end
        if (cmd.mul)
        begin
            sx_reg <= dx_reg * dx_reg;
            sy_reg <= dy_reg * dy_reg;
        end
        if (cmd.clr_best)
        begin
            best_reg <= '0;
        end
        else if (cmd.acc && (!found_reg || d < best_reg))
        begin
            best_reg <= d;
        end
    end

    assign count = count_reg;
    assign best = best_reg;
    assign found = found_reg;

endmodule

// ===== rtl/cpd_ctrl.sv =====
// controller: load points, then sweep all pairs one at a time
// depends on cpd_pkg
module cpd_ctrl #(
    parameter int MAX_POINTS = cpd_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              last_point,
    output logic                              out_valid,
    input  logic                              out_ready,
    input  logic [$clog2(MAX_POINTS+1)-1:0]   count,
    output cpd_pkg::cmd_t                     cmd,
    output logic [$clog2(MAX_POINTS)-1:0]     raddr
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    cpd_pkg::state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;

    // state and index registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpd_pkg::ST_LOAD;
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        raddr = i_reg[AW-1:0];
        case (state_reg)
            cpd_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.wr_point = 1'b1;
                    if (last_point)
                    begin
                        cmd.clr_best = 1'b1;
                        i_next = '0;
                        state_next = cpd_pkg::ST_READ_I;
                    end
                end
            end
            cpd_pkg::ST_READ_I:
            begin
                // read anchor point i, or finish
                if (i_reg + 1'b1 >= count)
                begin
                    state_next = cpd_pkg::ST_OUT;
                end
                else
                begin
                    j_next = i_reg + 1'b1;
                    state_next = cpd_pkg::ST_READ_J;
                end
            end
            cpd_pkg::ST_READ_J:
            begin
                cmd.ld_i = (j_reg == i_reg + 1'b1);
                raddr = j_reg[AW-1:0];
                state_next = cpd_pkg::ST_WAIT;
            end
            cpd_pkg::ST_WAIT:
            begin
                cmd.ld_j = 1'b1;
                state_next = cpd_pkg::ST_MUL;
            end
            cpd_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = cpd_pkg::ST_ACC;
            end
            cpd_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (j_reg + 1'b1 >= count)
                begin
                    i_next = i_reg + 1'b1;
                    state_next = cpd_pkg::ST_READ_I;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = cpd_pkg::ST_READ_J;
                end
            end
            cpd_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.clr_count = 1'b1;
                    state_next = cpd_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = cpd_pkg::ST_LOAD;
            end
        endcase
    end

`ifndef SYNTH
    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cpd_pkg::ST_LOAD) |-> !in_ready)
        else $error("input accepted while computing");
    a_j_after_i: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpd_pkg::ST_ACC) |-> (j_reg > i_reg))
        else $error("pair index order broken");
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpd_pkg::ST_MUL) |=> $stable(count))
        else $error("count changed during sweep");
`endif

endmodule

// ===== rtl/closest_pair_distance.sv =====
// Closest pair distance: points load one word per cycle into on-chip memory.
// The word with last_point set starts a sweep over every pair: a memory read,
// difference, square and compare step per pair plus one anchor read per point,
// after which the result word is offered.
// Points beyond MAX_POINTS are dropped; a set of fewer than two points gives
// pair_found = 0 and min_dist_sq = 0. Input is held off during the sweep.
module closest_pair_distance #(
    parameter int MAX_POINTS = cpd_pkg::MAX_POINTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [cpd_pkg::COORD_W-1:0] x_coord,
    input  logic signed [cpd_pkg::COORD_W-1:0] y_coord,
    input  logic                               last_point,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cpd_pkg::DIST_W-1:0]         min_dist_sq,
    output logic                               pair_found
);

    cpd_pkg::cmd_t cmd;
    logic [$clog2(MAX_POINTS)-1:0] raddr;
    logic [$clog2(MAX_POINTS+1)-1:0] count;

    cpd_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .last_point(last_point), .out_valid(out_valid), .out_ready(out_ready),
        .count(count), .cmd(cmd), .raddr(raddr)
    );

    cpd_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .raddr(raddr),
        .x_in(x_coord), .y_in(y_coord), .count(count),
        .best(min_dist_sq), .found(pair_found)
    );

endmodule

// ===== dv/tb_closest_pair_distance.sv =====
// testbench for closest_pair_distance: directed and random point sets with a brute-force
// minimum pair distance predictor and an in-order scoreboard
// depends on rtl/cpd_pkg.sv and rtl/closest_pair_distance.sv
`timescale 1ns / 1ps

module tb_closest_pair_distance;

    localparam int NPTS = cpd_pkg::MAX_POINTS_DEF;
    localparam int COORD_W = cpd_pkg::COORD_W;
    localparam int DIST_W = cpd_pkg::DIST_W;
    localparam int N_ITEMS = 1950;
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    typedef struct {
        logic [DIST_W-1:0] dsq;
        logic              found;
    } pair_result_t;

    // point set model and in-order store of expected results
    class pair_scoreboard;
        logic signed [COORD_W-1:0] xs[$];
        logic signed [COORD_W-1:0] ys[$];
        pair_result_t              pending[$];
        int                        errors;

        function void note_point(logic signed [COORD_W-1:0] x,
                                 logic signed [COORD_W-1:0] y, logic last);
            pair_result_t r;
            longint dx;
            longint dy;
            logic [DIST_W-1:0] d;
            if (xs.size() < NPTS)
            begin
                xs.push_back(x);
                ys.push_back(y);
            end
            if (!last)
                return;
            r.dsq = '0;
            r.found = 1'b0;
            for (int i = 0; i < xs.size(); i++)
                for (int j = i + 1; j < xs.size(); j++)
                begin
                    dx = longint'(xs[i]) - longint'(xs[j]);
                    dy = longint'(ys[i]) - longint'(ys[j]);
                    d = DIST_W'(dx * dx + dy * dy);
                    if (!r.found || d < r.dsq)
                    begin
                        r.dsq = d;
                        r.found = 1'b1;
                    end
                end
            pending.push_back(r);
            xs.delete();
            ys.delete();
        endfunction

        function void check_result(logic [DIST_W-1:0] dsq, logic found);
            pair_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word dsq=%0d found=%0b", $realtime, dsq, found);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (dsq !== e.dsq)
            begin
                $display("%0t: min_dist_sq expected %0d actual %0d", $realtime, e.dsq, dsq);
                errors++;
            end
            if (found !== e.found)
            begin
                $display("%0t: pair_found expected %0b actual %0b", $realtime, e.found, found);
                errors++;
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] x_coord = '0;
    logic signed [COORD_W-1:0] y_coord = '0;
    logic                      last_point = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [DIST_W-1:0]         min_dist_sq;
    logic                      pair_found;

    pair_scoreboard sb = new();
    longint         cycles = 0;
    int             base_x;
    int             base_y;

    always #1 clk = ~clk;

    closest_pair_distance i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .last_point (last_point),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .min_dist_sq(min_dist_sq),
        .pair_found (pair_found)
    );

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stalls, check on accept
    initial
    begin
        int gap;
        @(posedge clk iff rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk iff out_valid);
            sb.check_result(min_dist_sq, pair_found);
        end
    end

    // send one point word and wait for it to be taken
    task automatic send_point(int x, int y, bit last, bit nogap);
        int gap;
        gap = nogap ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_coord <= COORD_W'(x);
        y_coord <= COORD_W'(y);
        last_point <= last;
        @(posedge clk iff in_ready);
        sb.note_point(COORD_W'(x), COORD_W'(y), last);
    endtask

    function automatic int rnd_coord();
        return int'($urandom) >>> 1;
    endfunction

    // coordinate near a set base, or a full-range extreme or random value now and then
    function automatic int near_coord(int b);
        case ($urandom_range(0, 9))
            0: return -1073741824;
            1: return 1073741823;
            2: return rnd_coord();
            default: return b + int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // stop sending and wait until every expected word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int sent;
        int n;
        bit burst;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single point, extremes, duplicates, both signs
        send_point(5, 5, 1'b1, 1'b0);
        send_point(-1073741824, -1073741824, 1'b0, 1'b0);
        send_point(1073741823, 1073741823, 1'b1, 1'b0);
        send_point(-1073741824, 1073741823, 1'b0, 1'b0);
        send_point(1073741823, -1073741824, 1'b1, 1'b0);
        send_point(7, -3, 1'b0, 1'b0);
        send_point(100, 100, 1'b0, 1'b0);
        send_point(7, -3, 1'b1, 1'b0);
        send_point(0, 0, 1'b0, 1'b0);
        send_point(0, 1, 1'b0, 1'b0);
        send_point(1, 0, 1'b0, 1'b0);
        send_point(-1, -1, 1'b1, 1'b0);
        send_point(-1, 0, 1'b0, 1'b0);
        send_point(-1, 0, 1'b0, 1'b0);
        send_point(-1, 0, 1'b1, 1'b0);
        // pause until all results are back
        wait_drained();
        sent = 15;

        // random sets, mostly small, one oversized set dropping extra points
        while (sent < N_ITEMS)
        begin
            if (sent > 600 && sent < 700)
                n = NPTS + 3;
            else if ($urandom_range(0, 9) == 0)
                n = $urandom_range(1, 2);
            else
                n = $urandom_range(2, 14);
            base_x = rnd_coord();
            base_y = rnd_coord();
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n; k++)
                send_point(near_coord(base_x), near_coord(base_y), k == n - 1,
                           burst || n > 100);
            sent += n;
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
